FILE: rtl/spa_pkg.sv
// Shared constants and types for the sparse polynomial adder.
package spa_pkg;

    localparam int TERMS_PER_LIST = 16;
    localparam int MAX_RESULTS    = 32;

    localparam int CNT_W = $clog2(TERMS_PER_LIST + 1);
    localparam int IDX_W = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    localparam int COEF_W = 16;
    localparam int EXPO_W = 16;
    localparam int SUM_W  = COEF_W + 1;

    typedef struct packed {
        logic [EXPO_W-1:0] expo;
        logic [COEF_W-1:0] coef;
    } t_term;

    typedef struct packed {
        logic a_ok;
        logic b_ok;
    } t_alu_ctl;

    typedef struct packed {
        logic              take_a;
        logic              take_b;
        logic              keep;
        logic [SUM_W-1:0]  coef;
        logic [EXPO_W-1:0] expo;
    } t_alu_out;

endpackage

FILE: rtl/spa_alu.sv
// Shared compare and add unit for one merge step.
module spa_alu (
    input  spa_pkg::t_alu_ctl i_ctl,
    input  spa_pkg::t_term    i_a,
    input  spa_pkg::t_term    i_b,
    output spa_pkg::t_alu_out o_res
);

    logic                       lt;
    logic                       gt;
    logic [spa_pkg::SUM_W-1:0]  ca;
    logic [spa_pkg::SUM_W-1:0]  cb;
    logic [spa_pkg::SUM_W-1:0]  sum;

    assign lt  = i_a.expo < i_b.expo;
    assign gt  = i_a.expo > i_b.expo;
    assign ca  = {i_a.coef[spa_pkg::COEF_W-1], i_a.coef};
    assign cb  = {i_b.coef[spa_pkg::COEF_W-1], i_b.coef};
    assign sum = ca + cb;

    always_comb begin
        o_res = '0;
        if (i_ctl.a_ok && (!i_ctl.b_ok || lt)) begin
            o_res.take_a = 1'b1;
            o_res.keep   = 1'b1;
            o_res.coef   = ca;
            o_res.expo   = i_a.expo;
        end else if (i_ctl.b_ok && (!i_ctl.a_ok || gt)) begin
            o_res.take_b = 1'b1;
            o_res.keep   = 1'b1;
            o_res.coef   = cb;
            o_res.expo   = i_b.expo;
        end else if (i_ctl.a_ok && i_ctl.b_ok) begin
            // equal exponents
            o_res.take_a = 1'b1;
            o_res.take_b = 1'b1;
            o_res.keep   = (sum != '0);
            o_res.coef   = sum;
            o_res.expo   = i_a.expo;
        end
    end

endmodule

FILE: rtl/sparse_polynomial_add.sv
// Sparse polynomial adder: term list loading, merge sequencer and output register.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+------------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready | tdata: coef, expo; tuser: op
//  m       | out | o_m_tvalid / i_m_tready | tdata: sum_coef, sum_expo; tlast: last;
//          |     |                         | tuser: empty_res, overflow
//
// Loading accepts one item per cycle. The item that ends the second list starts the merge:
// the shared compare/add unit does one step per cycle unless the output stalls (at most
// count_a + count_b steps), then the merge closes and the flush state gives the final item.
// Lists that could yield more than MAX_RESULTS terms get a counting pass over them first.
// o_s_tready is high only while loading. A stalled output holds the merge.
// Synchronous active-low reset clears counts, end marks and the sequencer.
module sparse_polynomial_add (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] coef, [31:16] expo
    input  logic        i_s_tuser,   // [0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [16:0] sum_coef, [32:17] sum_expo, zero fill
    output logic        o_m_tlast,
    output logic [1:0]  o_m_tuser    // [0] empty_res, [1] overflow
);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_MERGE = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    localparam int CW = spa_pkg::CNT_W;
    localparam int RW = spa_pkg::RES_W;

    spa_pkg::t_term store_a [spa_pkg::TERMS_PER_LIST];
    spa_pkg::t_term store_b [spa_pkg::TERMS_PER_LIST];

    logic [1:0]    r_state, n_state;
    logic          r_scan, n_scan;
    logic [CW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic          r_end_a, n_end_a, r_end_b, n_end_b;
    logic          r_drop, n_drop, r_cut, n_cut;
    logic [RW-1:0] r_n, n_n;
    logic          r_pend_v, n_pend_v;
    logic [spa_pkg::SUM_W-1:0]  r_pend_coef, n_pend_coef;
    logic [spa_pkg::EXPO_W-1:0] r_pend_expo, n_pend_expo;

    logic          r_out_v, n_out_v;
    logic [spa_pkg::SUM_W-1:0]  r_o_coef, n_o_coef;
    logic [spa_pkg::EXPO_W-1:0] r_o_expo, n_o_expo;
    logic          r_o_last, n_o_last, r_o_empty, n_o_empty, r_o_ovf, n_o_ovf;

    logic              in_acc;
    logic              out_free;
    logic              wr_a, wr_b;
    spa_pkg::t_term    in_term;
    spa_pkg::t_alu_ctl alu_ctl;
    spa_pkg::t_alu_out alu_res;
    logic              room;

    assign in_term.coef = i_s_tdata[15:0];
    assign in_term.expo = i_s_tdata[31:16];
    assign o_s_tready   = (r_state == S_LOAD);
    assign in_acc       = i_s_tvalid && o_s_tready;
    assign out_free     = !r_out_v || i_m_tready;

    assign wr_a = in_acc && !i_s_tuser && !r_end_a && (in_term.coef != '0)
                  && (r_cnt_a < CW'(spa_pkg::TERMS_PER_LIST));
    assign wr_b = in_acc && i_s_tuser && !r_end_b && (in_term.coef != '0)
                  && (r_cnt_b < CW'(spa_pkg::TERMS_PER_LIST));

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            store_a[r_cnt_a[spa_pkg::IDX_W-1:0]] <= in_term;
        end
        if (wr_b) begin
            store_b[r_cnt_b[spa_pkg::IDX_W-1:0]] <= in_term;
        end
    end

    assign alu_ctl.a_ok = r_i < r_cnt_a;
    assign alu_ctl.b_ok = r_j < r_cnt_b;

    spa_alu u_alu (
        .i_ctl (alu_ctl),
        .i_a   (store_a[r_i[spa_pkg::IDX_W-1:0]]),
        .i_b   (store_b[r_j[spa_pkg::IDX_W-1:0]]),
        .o_res (alu_res)
    );

    assign room = r_n < RW'(spa_pkg::MAX_RESULTS);

    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_i         = r_i;
        n_j         = r_j;
        n_end_a     = r_end_a;
        n_end_b     = r_end_b;
        n_drop      = r_drop;
        n_cut       = r_cut;
        n_n         = r_n;
        n_pend_v    = r_pend_v;
        n_pend_coef = r_pend_coef;
        n_pend_expo = r_pend_expo;
        n_out_v     = r_out_v && !i_m_tready;
        n_o_coef    = r_o_coef;
        n_o_expo    = r_o_expo;
        n_o_last    = r_o_last;
        n_o_empty   = r_o_empty;
        n_o_ovf     = r_o_ovf;

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (!i_s_tuser && !r_end_a) begin
                        if (in_term.coef == '0) begin
                            n_end_a = 1'b1;
                        end else if (wr_a) begin
                            n_cnt_a = r_cnt_a + 1'b1;
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                    if (i_s_tuser && !r_end_b) begin
                        if (in_term.coef == '0) begin
                            n_end_b = 1'b1;
                        end else if (wr_b) begin
                            n_cnt_b = r_cnt_b + 1'b1;
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                    if (n_end_a && n_end_b) begin
                        n_state  = S_MERGE;
                        n_i      = '0;
                        n_j      = '0;
                        n_n      = '0;
                        n_cut    = 1'b0;
                        n_pend_v = 1'b0;
                        n_scan   = ((CW+1)'(n_cnt_a) + (CW+1)'(n_cnt_b))
                                   > (CW+1)'(spa_pkg::MAX_RESULTS);
                    end
                end
            end
            S_MERGE: begin
                if (!alu_ctl.a_ok && !alu_ctl.b_ok) begin
                    if (r_scan) begin
                        n_scan = 1'b0;
                        n_i    = '0;
                        n_j    = '0;
                        n_n    = '0;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end else if (r_scan) begin
                    n_i = r_i + CW'(alu_res.take_a);
                    n_j = r_j + CW'(alu_res.take_b);
                    if (alu_res.keep && room) begin
                        n_n = r_n + 1'b1;
                    end else if (alu_res.keep) begin
                        n_cut = 1'b1;
                    end
                end else if (!(alu_res.keep && room && r_pend_v && !out_free)) begin
                    n_i = r_i + CW'(alu_res.take_a);
                    n_j = r_j + CW'(alu_res.take_b);
                    if (alu_res.keep && room) begin
                        n_n         = r_n + 1'b1;
                        n_pend_v    = 1'b1;
                        n_pend_coef = alu_res.coef;
                        n_pend_expo = alu_res.expo;
                        if (r_pend_v) begin
                            n_out_v   = 1'b1;
                            n_o_coef  = r_pend_coef;
                            n_o_expo  = r_pend_expo;
                            n_o_last  = 1'b0;
                            n_o_empty = 1'b0;
                            n_o_ovf   = r_drop || r_cut;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_v   = 1'b1;
                    n_o_last  = 1'b1;
                    n_o_ovf   = r_drop || r_cut;
                    n_o_empty = !r_pend_v;
                    n_o_coef  = r_pend_v ? r_pend_coef : '0;
                    n_o_expo  = r_pend_v ? r_pend_expo : '0;
                    n_cnt_a   = '0;
                    n_cnt_b   = '0;
                    n_end_a   = 1'b0;
                    n_end_b   = 1'b0;
                    n_drop    = 1'b0;
                    n_pend_v  = 1'b0;
                    n_state   = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_scan   <= 1'b0;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_end_a  <= 1'b0;
            r_end_b  <= 1'b0;
            r_drop   <= 1'b0;
            r_cut    <= 1'b0;
            r_n      <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scan   <= n_scan;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_i      <= n_i;
            r_j      <= n_j;
            r_end_a  <= n_end_a;
            r_end_b  <= n_end_b;
            r_drop   <= n_drop;
            r_cut    <= n_cut;
            r_n      <= n_n;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_coef <= n_pend_coef;
        r_pend_expo <= n_pend_expo;
        r_o_coef    <= n_o_coef;
        r_o_expo    <= n_o_expo;
        r_o_last    <= n_o_last;
        r_o_empty   <= n_o_empty;
        r_o_ovf     <= n_o_ovf;
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {7'd0, r_o_expo, r_o_coef};
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = {r_o_ovf, r_o_empty};

endmodule
